// ===== sv/id3v2_frame_walker_assert.svh =====
// assertion macros for the id3v2 frame walker
`ifndef ID3V2_FRAME_WALKER_ASSERT_SVH
`define ID3V2_FRAME_WALKER_ASSERT_SVH

`ifndef SYNTHESIS

// plain property, clocked and disabled during reset
`define FW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("frame walker check failed");

// implication form built on the plain one
`define FW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  `FW_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`else

`define FW_ASSERT(label, clk, rst_n, prop)
`define FW_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/id3fw_pkg.sv =====
package id3fw_pkg;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_FRAME   = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_SKIP    = 3'd4,
    PH_FINISH  = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    K_HEADER_OK   = 3'd0,
    K_FRAME       = 3'd1,
    K_PAYLOAD     = 3'd2,
    K_DONE        = 3'd3,
    K_NOT_TAG     = 3'd4,
    K_BAD_VERSION = 3'd5,
    K_BAD_FLAGS   = 3'd6,
    K_BROKEN      = 3'd7
  } kind_e;

  typedef enum logic [3:0] {
    TF_NONE   = 4'd0,
    TF_YEAR   = 4'd1,
    TF_ALBUM  = 4'd2,
    TF_TITLE  = 4'd3,
    TF_ARTIST = 4'd4,
    TF_TRACK  = 4'd5,
    TF_GENRE  = 4'd6,
    TF_BPM    = 4'd7,
    TF_USER   = 4'd8,
    TF_UFID   = 4'd9
  } text_field_e;

  localparam logic [1:0] VER_NONE = 2'd0;
  localparam logic [1:0] VER_2    = 2'd2;
  localparam logic [1:0] VER_3    = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       tag_start;
  } id3fw_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  tag_version;
    logic [31:0] length_value;
    logic [31:0] frame_ident;
    logic [3:0]  text_field;
    logic [7:0]  payload_value;
    logic        last_payload;
  } id3fw_out_t;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  byte_index;
    logic        is_version_three;
    logic [28:0] tag_remaining;
    logic [31:0] ident_shift;
    logic [31:0] size_shift;
    logic [31:0] payload_remaining;
    logic [3:0]  field_code;
    logic        at_first_payload;
  } id3fw_state_t;

endpackage

// ===== sv/id3v2_frame_walker.sv =====
// id3v2 frame walker: takes an id3v2 tag one byte per request, with tag_start marking
// the first header byte, and returns header, frame, text payload, done and error results.
// one byte is accepted every cycle while the output side does not stall; a byte's result
// is registered twice: the input register captures the byte when it is taken and the single
// step of logic loads the result register from it.
// bytes that cause no result (skipped payload, header bytes, idle) leave nothing behind.
// the only stall comes from the output side: while a result waits, a byte in the input register
// that would make a result is held, and the next request is taken once the result moves on.
module id3v2_frame_walker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  id3fw_pkg::id3fw_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output id3fw_pkg::id3fw_out_t out_data_o
);
  import id3fw_pkg::*;

  // input register
  logic         in_valid_q;
  id3fw_in_t    in_q;

  // parse state
  id3fw_state_t state_q;
  id3fw_state_t state_d;

  // result register
  logic         out_valid_q;
  id3fw_out_t   out_q;

  id3fw_out_t   result;
  logic         emit;
  logic         step_fire;
  logic         out_free;

  // decode used by the checks at the end
  logic         in_body_phase;
  logic         out_is_payload;
  logic         out_ver_expected;
  logic         out_stalled;

  id3fw_step u_step (
    .state_i  (state_q),
    .in_i     (in_q),
    .state_o  (state_d),
    .result_o (result),
    .emit_o   (emit)
  );

  // the result register is free when empty or being drained this cycle
  assign out_free  = !out_valid_q || out_ready_i;
  // a byte with no result never waits on the output side
  assign step_fire = in_valid_q && (!emit || out_free);
  assign in_ready_o = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // all-zero state is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_body_phase    = state_q.phase == PH_PAYLOAD || state_q.phase == PH_SKIP;
  assign out_is_payload   = out_valid_o && out_data_o.kind == K_PAYLOAD;
  // every kind except the mark and version errors carries a known version; the check also leaves out the flags error
  assign out_ver_expected = out_valid_o && out_data_o.kind != K_NOT_TAG
                            && out_data_o.kind != K_BAD_VERSION
                            && out_data_o.kind != K_BAD_FLAGS;
  assign out_stalled      = out_valid_q && !out_ready_i;

`include "id3v2_frame_walker_assert.svh"

  // payload and skip phases always have bytes left to consume
  `FW_ASSERT_IMPL(a_payload_left, clk_i, rst_ni, in_body_phase, state_q.payload_remaining != '0)

  // forwarded payload bytes always belong to a known text frame
  `FW_ASSERT_IMPL(a_payload_field, clk_i, rst_ni, out_is_payload, out_data_o.text_field != TF_NONE)

  // every result after a good header carries version 2 or 3
  `FW_ASSERT_IMPL(a_version_known, clk_i, rst_ni, out_ver_expected, out_data_o.tag_version[1])

  // a result produced while the old one stalls would be lost
  `FW_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_stalled && in_valid_q, !(step_fire && emit))

endmodule

// ===== sv/id3fw_step.sv =====
module id3fw_step (
  input  id3fw_pkg::id3fw_state_t state_i,
  input  id3fw_pkg::id3fw_in_t    in_i,
  output id3fw_pkg::id3fw_state_t state_o,
  output id3fw_pkg::id3fw_out_t   result_o,
  output logic                    emit_o
);
  import id3fw_pkg::*;

  localparam logic [7:0] MARK_I = 8'h49;
  localparam logic [7:0] MARK_D = 8'h44;
  localparam logic [7:0] MARK_3 = 8'h33;

  function automatic logic [31:0] q4(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c, input logic [7:0] d);
    q4 = {a, b, c, d};
  endfunction

  function automatic text_field_e text_code(input logic [31:0] id);
    text_field_e r;
    r = TF_NONE;
    if (id == q4("T", "Y", "E", 8'h00) || id == q4("T", "Y", "E", "R")) r = TF_YEAR;
    else if (id == q4("T", "A", "L", 8'h00) || id == q4("T", "A", "L", "B")) r = TF_ALBUM;
    else if (id == q4("T", "T", "2", 8'h00) || id == q4("T", "I", "T", "2")) r = TF_TITLE;
    else if (id == q4("T", "P", "1", 8'h00) || id == q4("T", "P", "E", "1")) r = TF_ARTIST;
    else if (id == q4("T", "R", "K", 8'h00) || id == q4("T", "R", "C", "K")) r = TF_TRACK;
    else if (id == q4("T", "C", "O", "N")) r = TF_GENRE;
    else if (id == q4("T", "B", "P", 8'h00) || id == q4("T", "B", "P", "M")) r = TF_BPM;
    else if (id == q4("T", "X", "X", "X")) r = TF_USER;
    else if (id == q4("U", "F", "I", "D")) r = TF_UFID;
    return r;
  endfunction

  id3fw_state_t s;
  id3fw_out_t   res;
  logic         emit;
  logic         known_ver;
  logic [7:0]   b;
  logic [3:0]   hl;
  logic [3:0]   idlen;
  logic [3:0]   bi_next;
  logic [31:0]  id;
  logic [32:0]  need;
  logic [7:0]   mark;

  always_comb begin
    s         = state_i;
    res       = '0;
    emit      = 1'b0;
    known_ver = 1'b1;
    b         = in_i.data_byte;
    hl        = state_i.is_version_three ? 4'd10 : 4'd6;
    idlen     = state_i.is_version_three ? 4'd4 : 4'd3;
    bi_next   = '0;
    id        = '0;
    need      = '0;
    mark      = MARK_I;

    if (in_i.tag_start) begin
      s       = '0;
      s.phase = PH_HEADER;
      hl      = 4'd6;
      idlen   = 4'd3;
    end

    case (s.phase)
      PH_HEADER: begin
        case (s.byte_index[1:0])
          2'd0:    mark = MARK_I;
          2'd1:    mark = MARK_D;
          default: mark = MARK_3;
        endcase
        if (s.byte_index < 4'd3) begin
          if (b != mark) begin
            res.kind  = K_NOT_TAG;
            known_ver = 1'b0;
            emit      = 1'b1;
            s.phase   = PH_IDLE;
          end
        end else if (s.byte_index == 4'd3) begin
          if (b == 8'd3) s.is_version_three = 1'b1;
          else if (b == 8'd2) s.is_version_three = 1'b0;
          else begin
            res.kind  = K_BAD_VERSION;
            known_ver = 1'b0;
            emit      = 1'b1;
            s.phase   = PH_IDLE;
          end
        end else if (s.byte_index == 4'd5) begin
          if (b != 8'd0) begin
            res.kind = K_BAD_FLAGS;
            emit     = 1'b1;
            s.phase  = PH_IDLE;
          end
        end else if (s.byte_index >= 4'd6) begin
          s.size_shift = {s.size_shift[24:0], 7'd0} | {24'd0, b};
          if (s.byte_index == 4'd9) begin
            s.tag_remaining  = s.size_shift[28:0];
            res.kind         = K_HEADER_OK;
            res.length_value = {3'd0, s.tag_remaining};
            emit             = 1'b1;
          end
        end
        if (emit && res.kind == K_HEADER_OK) begin
          // header done: move on to the frames or finish an empty tag
          s.phase      = (s.tag_remaining != '0) ? PH_FRAME : PH_FINISH;
          s.byte_index = '0;
        end else if (s.phase == PH_HEADER) begin
          s.byte_index = s.byte_index + 4'd1;
        end
      end

      PH_FRAME: begin
        if (s.byte_index == 4'd0 && s.tag_remaining < {25'd0, hl}) begin
          res.kind = K_BROKEN;
          emit     = 1'b1;
          s.phase  = PH_IDLE;
        end else begin
          if (s.byte_index == 4'd0) begin
            s.ident_shift = '0;
            s.size_shift  = '0;
          end
          if (s.byte_index < idlen) s.ident_shift = {s.ident_shift[23:0], b};
          else if (s.byte_index < {idlen[2:0], 1'b0})
            s.size_shift = {s.size_shift[23:0], b};
          bi_next      = s.byte_index + 4'd1;
          s.byte_index = bi_next;
          if (bi_next >= hl) begin
            id               = s.is_version_three ? s.ident_shift
                                                  : {s.ident_shift[23:0], 8'd0};
            need             = {1'b0, s.size_shift} + {29'd0, hl};
            s.byte_index     = '0;
            res.frame_ident  = id;
            res.length_value = s.size_shift;
            emit             = 1'b1;
            if (need > {4'd0, s.tag_remaining}) begin
              res.kind = K_BROKEN;
              s.phase  = PH_IDLE;
            end else if (id[31:24] == 8'd0) begin
              res.kind         = K_DONE;
              res.frame_ident  = '0;
              res.length_value = '0;
              s.phase          = PH_IDLE;
            end else begin
              res.kind            = K_FRAME;
              s.field_code        = text_code(id);
              res.text_field      = s.field_code;
              s.tag_remaining     = s.tag_remaining - need[28:0];
              s.payload_remaining = s.size_shift;
              s.at_first_payload  = 1'b1;
              if (s.size_shift == '0)
                s.phase = (s.tag_remaining != '0) ? PH_FRAME : PH_FINISH;
              else
                s.phase = (s.field_code != TF_NONE) ? PH_PAYLOAD : PH_SKIP;
            end
          end
        end
      end

      PH_PAYLOAD: begin
        if (s.payload_remaining != '0) s.payload_remaining = s.payload_remaining - 32'd1;
        // a leading zero is the text encoding byte and is not forwarded
        if (!(s.at_first_payload && b == 8'd0)) begin
          res.kind          = K_PAYLOAD;
          res.payload_value = b;
          res.text_field    = s.field_code;
          res.last_payload  = (s.payload_remaining == '0);
          emit              = 1'b1;
        end
        s.at_first_payload = 1'b0;
        if (s.payload_remaining == '0) begin
          s.phase      = (s.tag_remaining != '0) ? PH_FRAME : PH_FINISH;
          s.byte_index = '0;
        end
      end

      PH_SKIP: begin
        if (s.payload_remaining != '0) s.payload_remaining = s.payload_remaining - 32'd1;
        if (s.payload_remaining == '0) begin
          s.phase      = (s.tag_remaining != '0) ? PH_FRAME : PH_FINISH;
          s.byte_index = '0;
        end
      end

      PH_FINISH: begin
        res.kind = K_DONE;
        emit     = 1'b1;
        s.phase  = PH_IDLE;
      end

      default: begin
      end
    endcase

    res.tag_version = known_ver ? (s.is_version_three ? VER_3 : VER_2) : VER_NONE;
  end

  assign state_o  = s;
  assign result_o = res;
  assign emit_o   = emit;

endmodule
